>>> rtl/core/lidar_sector_obstacle_avoid_unit_assert.svh
// Assertion macros used by the port-level checker of the sector obstacle unit
`ifndef LIDAR_SECTOR_OBSTACLE_AVOID_UNIT_ASSERT_SVH
`define LIDAR_SECTOR_OBSTACLE_AVOID_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define LSOA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define LSOA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lsoa_pkg.sv
// Types, constants and register codes of the lidar sector obstacle unit
package lsoa_pkg;

    localparam int RANGE_BITS_DEF      = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 20;

    localparam int RANGE_W     = 16;
    localparam int START_W     = 23;
    localparam int STEP_W      = 21;
    localparam int LIMIT_W     = 16;
    localparam int SPEED_W     = 16;
    localparam int LIN_W       = 17;
    localparam int TURN_W      = 2;
    localparam int ACC_W       = 32;
    localparam int CFG_DATA_W  = 23;
    localparam int CFG_ADDR_W  = 3;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // floor(pi * 2^48)
    localparam longint unsigned PI_Q48 = 64'h3243F6A8885A3;

    localparam logic [START_W-1:0] ANGLE_START_RST   = 23'h4DBC09;  // -3294199
    localparam logic [STEP_W-1:0]  ANGLE_STEP_RST    = 21'd18301;
    localparam logic [LIMIT_W-1:0] NEAR_LIMIT_RST    = 16'd300;
    localparam logic [LIMIT_W-1:0] STEER_LIMIT_RST   = 16'd600;
    localparam logic [SPEED_W-1:0] FORWARD_SPEED_RST = 16'd400;
    localparam logic [SPEED_W-1:0] REVERSE_SPEED_RST = 16'd500;

    localparam logic [TURN_W-1:0] TURN_NONE  = 2'b00;
    localparam logic [TURN_W-1:0] TURN_LEFT  = 2'b01;
    localparam logic [TURN_W-1:0] TURN_RIGHT = 2'b11;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ANGLE_START   = 3'd0,
        REG_ANGLE_STEP    = 3'd1,
        REG_NEAR_LIMIT    = 3'd2,
        REG_STEER_LIMIT   = 3'd3,
        REG_FORWARD_SPEED = 3'd4,
        REG_REVERSE_SPEED = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic                 load_start;
        logic [START_W-1:0]   load_value;
        logic [START_W-1:0]   angle_start;
        logic [STEP_W-1:0]    angle_step;
        logic [LIMIT_W-1:0]   near_limit;
        logic [LIMIT_W-1:0]   steer_limit;
        logic [SPEED_W-1:0]   forward_speed;
        logic [SPEED_W-1:0]   reverse_speed;
    } cfg_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic               last_sample;
    } in_item_t;

endpackage

>>> rtl/core/lsoa_cfg_regs.sv
// Configuration register file of the lidar sector obstacle unit
module lsoa_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lsoa_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lsoa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output lsoa_pkg::cfg_t                  cfg
);
    import lsoa_pkg::*;

    logic [START_W-1:0] start_reg, start_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [LIMIT_W-1:0] near_reg, near_next;
    logic [LIMIT_W-1:0] steer_reg, steer_next;
    logic [SPEED_W-1:0] fwd_reg, fwd_next;
    logic [SPEED_W-1:0] rev_reg, rev_next;
    logic               load_start;

    always_comb
    begin
        start_next = start_reg;
        step_next  = step_reg;
        near_next  = near_reg;
        steer_next = steer_reg;
        fwd_next   = fwd_reg;
        rev_next   = rev_reg;
        load_start = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_ANGLE_START:
                begin
                    start_next = cfg_wdata[START_W-1:0];
                    load_start = 1'b1;
                end
                REG_ANGLE_STEP:    step_next  = cfg_wdata[STEP_W-1:0];
                REG_NEAR_LIMIT:    near_next  = cfg_wdata[LIMIT_W-1:0];
                REG_STEER_LIMIT:   steer_next = cfg_wdata[LIMIT_W-1:0];
                REG_FORWARD_SPEED: fwd_next   = cfg_wdata[SPEED_W-1:0];
                REG_REVERSE_SPEED: rev_next   = cfg_wdata[SPEED_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= ANGLE_START_RST;
            step_reg  <= ANGLE_STEP_RST;
            near_reg  <= NEAR_LIMIT_RST;
            steer_reg <= STEER_LIMIT_RST;
            fwd_reg   <= FORWARD_SPEED_RST;
            rev_reg   <= REVERSE_SPEED_RST;
        end
        else
        begin
            start_reg <= start_next;
            step_reg  <= step_next;
            near_reg  <= near_next;
            steer_reg <= steer_next;
            fwd_reg   <= fwd_next;
            rev_reg   <= rev_next;
        end
    end

    // the start write also reloads the angle accumulator in the same edge
    assign cfg.load_start    = load_start;
    assign cfg.load_value    = cfg_wdata[START_W-1:0];
    assign cfg.angle_start   = start_reg;
    assign cfg.angle_step    = step_reg;
    assign cfg.near_limit    = near_reg;
    assign cfg.steer_limit   = steer_reg;
    assign cfg.forward_speed = fwd_reg;
    assign cfg.reverse_speed = rev_reg;

endmodule

>>> rtl/core/lsoa_in_stage.sv
// Input register stage of the lidar sector obstacle unit
module lsoa_in_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lsoa_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                            s_tlast,
    output logic                            item_valid,
    output lsoa_pkg::in_item_t              item,
    input  logic                            item_take
);
    import lsoa_pkg::*;

    logic     valid_reg, valid_next;
    in_item_t item_reg;
    logic     accept;

    assign s_tready = !valid_reg || item_take;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (item_take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.range_mm    <= s_tdata[RANGE_W-1:0];
            item_reg.last_sample <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/core/lsoa_sweep.sv
// Sweep state, sector tests and result register of the lidar sector obstacle unit
module lsoa_sweep #(
    parameter int RANGE_BITS      = lsoa_pkg::RANGE_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = lsoa_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lsoa_pkg::cfg_t                   cfg,
    input  logic                             item_valid,
    input  lsoa_pkg::in_item_t               item,
    output logic                             item_take,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lsoa_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import lsoa_pkg::*;

    localparam int CMP_W = (RANGE_BITS > RANGE_W) ? RANGE_BITS : RANGE_W;
    localparam logic [CMP_W-1:0] RANGE_MAX = (CMP_W'(1) << RANGE_BITS) - CMP_W'(1);
    localparam longint unsigned SECTOR_DIV = 64'd6 << (48 - ANGLE_FRAC_BITS);
    // floor(pi/6 * 2^F) and floor(5*pi/6 * 2^F)
    localparam logic signed [ACC_W-1:0] T30  = ACC_W'(PI_Q48 / SECTOR_DIV);
    localparam logic signed [ACC_W-1:0] T150 = ACC_W'((64'd5 * PI_Q48) / SECTOR_DIV);

    logic signed [ACC_W-1:0] acc_reg, acc_next, acc_adv;
    logic                    front_reg, front_next, front_upd;
    logic                    rear_reg, rear_next, rear_upd;
    logic [RANGE_BITS-1:0]   left_reg, left_next, left_upd;
    logic [RANGE_BITS-1:0]   right_reg, right_next, right_upd;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0]  out_data_reg, out_data_next;

    logic [CMP_W-1:0]        range_w, range_sat;
    logic                    nonzero, below_near, below_steer;
    logic                    in_right, in_left, in_rear, front_test;
    logic                    out_free, emit;
    logic                    lin_pos;
    logic [LIN_W-1:0]        lin;
    logic [TURN_W-1:0]       turn;

    assign out_free  = !out_valid_reg || m_tready;
    assign item_take = item_valid && (!item.last_sample || out_free);
    assign emit      = item_take && item.last_sample;

    // sample path: advance angle, classify sector, update flags and minima
    always_comb
    begin
        range_w     = CMP_W'(item.range_mm);
        range_sat   = (range_w > RANGE_MAX) ? RANGE_MAX : range_w;
        nonzero     = (range_sat != '0);
        below_near  = range_sat < CMP_W'(cfg.near_limit);
        below_steer = range_sat < CMP_W'(cfg.steer_limit);

        acc_adv  = acc_reg + ACC_W'($signed(cfg.angle_step));
        in_right = !acc_adv[ACC_W-1] && (acc_adv <= T30);
        in_left  = acc_adv[ACC_W-1] && (acc_adv >= -T30);
        in_rear  = (acc_adv < -T150) || (acc_adv > T150);
        front_test = nonzero && !front_reg && (in_right || in_left);

        front_upd = front_reg || (front_test && below_near);
        rear_upd  = rear_reg || (nonzero && !rear_reg && in_rear && below_near);

        right_upd = right_reg;
        left_upd  = left_reg;
        if (front_test && !below_near && below_steer)
        begin
            if (in_right && (range_sat < CMP_W'(right_reg)))
                right_upd = range_sat[RANGE_BITS-1:0];
            if (in_left && (range_sat < CMP_W'(left_reg)))
                left_upd = range_sat[RANGE_BITS-1:0];
        end
    end

    // result from the state as left by this sample
    always_comb
    begin
        if (front_upd && rear_upd)
            lin = '0;
        else if (front_upd)
            lin = LIN_W'(0) - LIN_W'(cfg.reverse_speed);
        else
            lin = LIN_W'(cfg.forward_speed);

        lin_pos = !front_upd && (cfg.forward_speed != '0);
        if ((left_upd == right_upd) || !lin_pos)
            turn = TURN_NONE;
        else if (left_upd < right_upd)
            turn = TURN_LEFT;
        else
            turn = TURN_RIGHT;

        out_data_next = {3'b000, rear_upd, front_upd, turn, lin};
    end

    always_comb
    begin
        acc_next   = acc_reg;
        front_next = front_reg;
        rear_next  = rear_reg;
        left_next  = left_reg;
        right_next = right_reg;
        if (cfg.load_start)
            acc_next = ACC_W'($signed(cfg.load_value));
        else if (emit)
        begin
            // clear the sweep once its result is out
            acc_next   = ACC_W'($signed(cfg.angle_start));
            front_next = 1'b0;
            rear_next  = 1'b0;
            left_next  = '1;
            right_next = '1;
        end
        else if (item_take)
        begin
            acc_next   = acc_adv;
            front_next = front_upd;
            rear_next  = rear_upd;
            left_next  = left_upd;
            right_next = right_upd;
        end

        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= ACC_W'($signed(ANGLE_START_RST));
            front_reg     <= 1'b0;
            rear_reg      <= 1'b0;
            left_reg      <= '1;
            right_reg     <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            front_reg     <= front_next;
            rear_reg      <= rear_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> rtl/core/lidar_sector_obstacle_avoid_unit.sv
// Top level of the lidar sector obstacle avoidance unit
// Path: a last sample waits in the input register, then its result is held in the output register.
// Throughput: one sample per cycle; the input register and one output register set the pace.
// A stalled result only holds back a following last sample; other samples keep flowing.
// Reset (rst_n low, asynchronous): registers to defaults, angle to start, flags and minima clear.
module lidar_sector_obstacle_avoid_unit #(
    parameter int RANGE_BITS      = lsoa_pkg::RANGE_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = lsoa_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lsoa_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [lsoa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lsoa_pkg::IN_TDATA_W-1:0]  s_tdata,   // [15:0] range_mm
    input  logic                             s_tlast,   // last_sample
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [16:0] linear_speed, [18:17] turn_direction, [19] front_blocked,
    // [20] rear_blocked, [23:21] zero
    output logic [lsoa_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import lsoa_pkg::*;

    cfg_t     cfg;
    in_item_t item;
    logic     item_valid;
    logic     item_take;

    lsoa_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lsoa_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    lsoa_sweep #(
        .RANGE_BITS      (RANGE_BITS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_sweep (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

>>> rtl/core/lsoa_checker.sv
// Port-level checker of the lidar sector obstacle unit, bound to the top level
`include "lidar_sector_obstacle_avoid_unit_assert.svh"

module lsoa_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [lsoa_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import lsoa_pkg::*;

    `LSOA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item changed while stalled")
    `LSOA_ASSERT_NOW(a_turn_code, m_tvalid, m_tdata[18:17] != 2'b10, "turn direction out of range")
    `LSOA_ASSERT_NOW(a_turn_moving, m_tvalid && (m_tdata[18:17] != TURN_NONE), !m_tdata[16] && (m_tdata[16:0] != '0), "turn given without forward motion")
    `LSOA_ASSERT_NOW(a_both_stop, m_tvalid && m_tdata[19] && m_tdata[20], m_tdata[16:0] == '0, "both sides blocked but speed not zero")
    `LSOA_ASSERT_NOW(a_free_fwd, m_tvalid && !m_tdata[19], !m_tdata[16], "reverse speed with front clear")

endmodule

bind lidar_sector_obstacle_avoid_unit lsoa_checker u_lsoa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
